>>> rtl/core/yuv_saturation_adjust_macros.svh
// assertion macros shared by the saturation adjust rtl
`ifndef YUV_SATURATION_ADJUST_MACROS_SVH
`define YUV_SATURATION_ADJUST_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define YSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yuv saturation adjust: implication failed");

// next-cycle implication
`define YSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuv saturation adjust: next-cycle check failed");

// fixed-delay implication
`define YSA_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("yuv saturation adjust: latency check failed");

`endif

>>> rtl/core/yuvsat_pkg.sv
// constants, widths and coefficient helper for the saturation adjust pipeline
package yuvsat_pkg;

  // pixel channel format
  localparam int PIX_BITS = 8;
  localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

  // chroma gain, unsigned q4.8
  localparam int GAIN_BITS = 12;
  localparam int GAIN_FRAC = 8;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd256;

  // register port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_IDX_GAIN = 1'b0;

  // signed width of y, u and v with f fraction bits
  function automatic int yuv_w(input int f);
    return PIX_BITS + f + 2;
  endfunction

  // width of u and v after the gain
  function automatic int gain_w(input int f);
    return yuv_w(f) + GAIN_BITS + 1;
  endfunction

  // width of the inverse matrix sums
  function automatic int sum_w(input int f);
    return 2 * f + PIX_BITS + GAIN_BITS + 6;
  endfunction

  // coefficient in thousandths scaled by 2^f, rounded half away from zero
  function automatic int coef(input int milli, input int f);
    int scaled;
    scaled = milli * (1 << f);
    if (milli >= 0) begin
      return (scaled + 500) / 1000;
    end
    return (scaled - 500) / 1000;
  endfunction

endpackage

>>> rtl/core/yuvsat_cfg.sv
// register port holding the chroma gain
module yuvsat_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [yuvsat_pkg::ADDR_BITS-1:0] paddr,
  input  logic [yuvsat_pkg::DATA_BITS-1:0] pwdata,
  output logic [yuvsat_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready,
  output logic [yuvsat_pkg::GAIN_BITS-1:0] gain_o
);
  import yuvsat_pkg::*;

  `include "yuv_saturation_adjust_macros.svh"

  logic                 wr_en;
  logic                 reg_idx;
  logic [GAIN_BITS-1:0] gain_r;
  logic [GAIN_BITS-1:0] gain_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    gain_nxt = gain_r;
    if (wr_en && (reg_idx == REG_IDX_GAIN)) begin
      gain_nxt = pwdata[GAIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_IDX_GAIN: prdata = DATA_BITS'(gain_r);
      default:      prdata = '0;
    endcase
  end

  assign gain_o = gain_r;

  `YSA_ASSERT_NEXT(a_gain_write, wr_en && (reg_idx == REG_IDX_GAIN),
                   gain_r == $past(pwdata[GAIN_BITS-1:0]))

endmodule

>>> rtl/core/yuvsat_fwd.sv
// stage one: forward rgb to yuv matrix
module yuvsat_fwd #(
  parameter  int COEF_FRAC_BITS = 12,
  localparam int YUV_W          = yuvsat_pkg::yuv_w(COEF_FRAC_BITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  input  logic [yuvsat_pkg::PIX_BITS-1:0] red_i,
  input  logic [yuvsat_pkg::PIX_BITS-1:0] green_i,
  input  logic [yuvsat_pkg::PIX_BITS-1:0] blue_i,
  output logic                            vld_o,
  output logic signed [YUV_W-1:0]         y_o,
  output logic signed [YUV_W-1:0]         u_o,
  output logic signed [YUV_W-1:0]         v_o
);
  import yuvsat_pkg::*;

  localparam logic signed [YUV_W-1:0] C_YR = YUV_W'(coef(299, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_YG = YUV_W'(coef(587, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_YB = YUV_W'(coef(114, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_UR = YUV_W'(coef(-147, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_UG = YUV_W'(coef(-289, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_UB = YUV_W'(coef(436, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_VR = YUV_W'(coef(615, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_VG = YUV_W'(coef(-515, COEF_FRAC_BITS));
  localparam logic signed [YUV_W-1:0] C_VB = YUV_W'(coef(-100, COEF_FRAC_BITS));

  logic signed [YUV_W-1:0] r_s, g_s, b_s;
  logic signed [YUV_W-1:0] y_nxt, u_nxt, v_nxt;
  logic signed [YUV_W-1:0] y_r, u_r, v_r;
  logic                    vld_r;

  // pixels as positive signed values
  assign r_s = signed'(YUV_W'(red_i));
  assign g_s = signed'(YUV_W'(green_i));
  assign b_s = signed'(YUV_W'(blue_i));

  // constant-coefficient dot products
  assign y_nxt = C_YR * r_s + C_YG * g_s + C_YB * b_s;
  assign u_nxt = C_UR * r_s + C_UG * g_s + C_UB * b_s;
  assign v_nxt = C_VR * r_s + C_VG * g_s + C_VB * b_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  assign vld_o = vld_r;
  assign y_o   = y_r;
  assign u_o   = u_r;
  assign v_o   = v_r;

endmodule

>>> rtl/core/yuvsat_gain.sv
// stage two: chroma times saturation gain
module yuvsat_gain #(
  parameter  int COEF_FRAC_BITS = 12,
  localparam int YUV_W          = yuvsat_pkg::yuv_w(COEF_FRAC_BITS),
  localparam int GAIN_W         = yuvsat_pkg::gain_w(COEF_FRAC_BITS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [yuvsat_pkg::GAIN_BITS-1:0] gain_i,
  input  logic signed [YUV_W-1:0]          y_i,
  input  logic signed [YUV_W-1:0]          u_i,
  input  logic signed [YUV_W-1:0]          v_i,
  output logic                             vld_o,
  output logic signed [YUV_W-1:0]          y_o,
  output logic signed [GAIN_W-1:0]         u_o,
  output logic signed [GAIN_W-1:0]         v_o
);
  import yuvsat_pkg::*;

  logic signed [GAIN_W-1:0] k_s;
  logic signed [GAIN_W-1:0] u_nxt, v_nxt;
  logic signed [GAIN_W-1:0] u_r, v_r;
  logic signed [YUV_W-1:0]  y_r;
  logic                     vld_r;

  // gain is unsigned, so zero extend before the signed multiply
  assign k_s   = signed'(GAIN_W'(gain_i));
  assign u_nxt = GAIN_W'(u_i) * k_s;
  assign v_nxt = GAIN_W'(v_i) * k_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_i;
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  assign vld_o = vld_r;
  assign y_o   = y_r;
  assign u_o   = u_r;
  assign v_o   = v_r;

endmodule

>>> rtl/core/yuvsat_inv.sv
// stage three: inverse yuv to rgb matrix at full precision
module yuvsat_inv #(
  parameter  int COEF_FRAC_BITS = 12,
  localparam int YUV_W          = yuvsat_pkg::yuv_w(COEF_FRAC_BITS),
  localparam int GAIN_W         = yuvsat_pkg::gain_w(COEF_FRAC_BITS),
  localparam int SUM_W          = yuvsat_pkg::sum_w(COEF_FRAC_BITS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  logic signed [YUV_W-1:0]  y_i,
  input  logic signed [GAIN_W-1:0] u_i,
  input  logic signed [GAIN_W-1:0] v_i,
  output logic                     vld_o,
  output logic signed [SUM_W-1:0]  red_o,
  output logic signed [SUM_W-1:0]  green_o,
  output logic signed [SUM_W-1:0]  blue_o
);
  import yuvsat_pkg::*;

  localparam int Y_SHIFT = COEF_FRAC_BITS + GAIN_FRAC;

  localparam logic signed [SUM_W-1:0] C_RV = SUM_W'(coef(1140, COEF_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] C_GU = SUM_W'(coef(-395, COEF_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] C_GV = SUM_W'(coef(-581, COEF_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] C_BU = SUM_W'(coef(2032, COEF_FRAC_BITS));

  logic signed [SUM_W-1:0] ys, u_s, v_s;
  logic signed [SUM_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic signed [SUM_W-1:0] red_r, green_r, blue_r;
  logic                    vld_r;

  // bring y up to the fraction point of the chroma products
  assign ys  = SUM_W'(y_i) <<< Y_SHIFT;
  assign u_s = SUM_W'(u_i);
  assign v_s = SUM_W'(v_i);

  assign red_nxt   = ys + C_RV * v_s;
  assign green_nxt = ys + C_GU * u_s + C_GV * v_s;
  assign blue_nxt  = ys + C_BU * u_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign vld_o   = vld_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

>>> rtl/core/yuvsat_clamp.sv
// stage four: round to nearest, saturate to pixel range, output registers
module yuvsat_clamp #(
  parameter  int COEF_FRAC_BITS = 12,
  localparam int SUM_W          = yuvsat_pkg::sum_w(COEF_FRAC_BITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  input  logic signed [SUM_W-1:0]         red_i,
  input  logic signed [SUM_W-1:0]         green_i,
  input  logic signed [SUM_W-1:0]         blue_i,
  output logic                            vld_o,
  output logic [yuvsat_pkg::PIX_BITS-1:0] red_o,
  output logic [yuvsat_pkg::PIX_BITS-1:0] green_o,
  output logic [yuvsat_pkg::PIX_BITS-1:0] blue_o,
  output logic                            clip_o
);
  import yuvsat_pkg::*;

  localparam int OUT_SHIFT = 2 * COEF_FRAC_BITS + GAIN_FRAC;
  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] MAX_S = signed'(SUM_W'(PIX_MAX));

  // round half up, then clamp; msb of the result is the clip flag
  function automatic logic [PIX_BITS:0] round_clamp(input logic signed [SUM_W-1:0] val);
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] rounded;
    biased  = val + HALF;
    rounded = biased >>> OUT_SHIFT;
    if (rounded < 0) begin
      return {1'b1, {PIX_BITS{1'b0}}};
    end
    if (rounded > MAX_S) begin
      return {1'b1, PIX_MAX};
    end
    return {1'b0, rounded[PIX_BITS-1:0]};
  endfunction

  logic [PIX_BITS:0]   red_c, green_c, blue_c;
  logic [PIX_BITS-1:0] red_r, green_r, blue_r;
  logic                clip_r;
  logic                clip_nxt;
  logic                vld_r;

  assign red_c    = round_clamp(red_i);
  assign green_c  = round_clamp(green_i);
  assign blue_c   = round_clamp(blue_i);
  assign clip_nxt = red_c[PIX_BITS] | green_c[PIX_BITS] | blue_c[PIX_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_c[PIX_BITS-1:0];
    green_r <= green_c[PIX_BITS-1:0];
    blue_r  <= blue_c[PIX_BITS-1:0];
    clip_r  <= clip_nxt;
  end

  assign vld_o   = vld_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;
  assign clip_o  = clip_r;

endmodule

>>> rtl/core/yuv_saturation_adjust.sv
// top level of the rgb saturation adjust pipeline
//
// Usage
//   Input channel: drive in_red, in_green and in_blue and raise start; the
//   item is taken at the clock edge where start is high and busy is low.
//   busy is held low, so one pixel can be taken on every clock.
//   Result channel: out_valid is high for exactly one cycle with out_red,
//   out_green, out_blue and out_clipped; the receiver cannot stall, so the
//   result must be captured at the edge that ends that cycle.
//   Each item taken passes through four register stages (forward matrix,
//   gain multiply, inverse matrix, round and clamp) before it is on the
//   outputs. Throughput is one item per cycle; each of the stages takes a
//   new item every clock.
//   Register port: chroma gain at byte address 0, unsigned q4.8, reset to
//   1.0. Write it only while no items are in flight.
//   Reset (rst_n low, synchronous) clears all stage valid bits, so nothing
//   in flight is delivered, and sets the gain back to 1.0.
module yuv_saturation_adjust #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             start,
  output logic                             busy,
  input  logic [yuvsat_pkg::PIX_BITS-1:0]  in_red,
  input  logic [yuvsat_pkg::PIX_BITS-1:0]  in_green,
  input  logic [yuvsat_pkg::PIX_BITS-1:0]  in_blue,
  // result channel
  output logic                             out_valid,
  output logic [yuvsat_pkg::PIX_BITS-1:0]  out_red,
  output logic [yuvsat_pkg::PIX_BITS-1:0]  out_green,
  output logic [yuvsat_pkg::PIX_BITS-1:0]  out_blue,
  output logic                             out_clipped,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [yuvsat_pkg::ADDR_BITS-1:0] paddr,
  input  logic [yuvsat_pkg::DATA_BITS-1:0] pwdata,
  output logic [yuvsat_pkg::DATA_BITS-1:0] prdata,
  output logic                             pready
);
  import yuvsat_pkg::*;

  `include "yuv_saturation_adjust_macros.svh"

  localparam int YUV_W  = yuv_w(COEF_FRAC_BITS);
  localparam int GAIN_W = gain_w(COEF_FRAC_BITS);
  localparam int SUM_W  = sum_w(COEF_FRAC_BITS);

  logic                 in_take;
  logic [GAIN_BITS-1:0] gain;

  logic                    s1_vld;
  logic signed [YUV_W-1:0] s1_y, s1_u, s1_v;

  logic                     s2_vld;
  logic signed [YUV_W-1:0]  s2_y;
  logic signed [GAIN_W-1:0] s2_u, s2_v;

  logic                    s3_vld;
  logic signed [SUM_W-1:0] s3_red, s3_green, s3_blue;

  // the pipeline never stalls
  assign busy    = 1'b0;
  assign in_take = start && !busy;

  yuvsat_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_o  (gain)
  );

  yuvsat_fwd #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_take),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .vld_o   (s1_vld),
    .y_o     (s1_y),
    .u_o     (s1_u),
    .v_o     (s1_v)
  );

  yuvsat_gain #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld),
    .gain_i (gain),
    .y_i    (s1_y),
    .u_i    (s1_u),
    .v_i    (s1_v),
    .vld_o  (s2_vld),
    .y_o    (s2_y),
    .u_o    (s2_u),
    .v_o    (s2_v)
  );

  yuvsat_inv #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_inv (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s2_vld),
    .y_i     (s2_y),
    .u_i     (s2_u),
    .v_i     (s2_v),
    .vld_o   (s3_vld),
    .red_o   (s3_red),
    .green_o (s3_green),
    .blue_o  (s3_blue)
  );

  yuvsat_clamp #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_clamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s3_vld),
    .red_i   (s3_red),
    .green_i (s3_green),
    .blue_i  (s3_blue),
    .vld_o   (out_valid),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue),
    .clip_o  (out_clipped)
  );

  // every item taken comes out on the result channel, and nothing else does
  `YSA_ASSERT_DELAY(a_item_latency, in_take, 4, out_valid)
  `YSA_ASSERT_IMPL(a_no_spurious_result, out_valid, $past(in_take, 4))
  `YSA_ASSERT_IMPL(a_stage_chain, s3_vld, $past(s1_vld, 2))

endmodule
